// ===== rtl/core/rlr_pkg.sv =====
// Shared types, constants and helpers for the shuffled LCG range unit.
// No dependencies; used by rlr_ctrl, rlr_dp and the top level.
package rlr_pkg;

   // Shuffle table geometry. The index comes from the top bits of the last output,
   // so the depth is a power of two.
   localparam int TABLE_DEPTH = 32;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int IDX_LSB     = 31 - IDX_W;
   localparam int WARM_STEPS  = TABLE_DEPTH + 8;
   localparam int CNT_W       = $clog2(WARM_STEPS);

   // Park-Miller minimal standard
   localparam int PM_A   = 16807;
   localparam int PROD_W = 46;
   localparam logic [31:0] PM_M      = 32'h7FFF_FFFF;
   localparam logic [31:0] HALF_WORD = 32'h8000_0000;

   // Request kinds
   localparam logic [1:0] KIND_SEED  = 2'd0;
   localparam logic [1:0] KIND_DRAW  = 2'd1;
   localparam logic [1:0] KIND_RANGE = 2'd2;

   typedef struct packed {
      logic capture;
      logic seed_load;
      logic draw_init;
      logic mul;
      logic warm_red;
      logic step_red;
      logic swap;
      logic div_lim_start;
      logic div_mod_start;
      logic div_step;
      logic lim_save;
      logic res_low;
      logic res_draw;
      logic res_mod;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic warm_need;
      logic warm_last;
      logic degenerate;
      logic div_last;
      logic reject;
   } stat_type;

   // 16807 * v mod (2^31 - 1), using 2^31 = 1 (mod M)
   function automatic logic [30:0] pm_fold(input logic [PROD_W-1:0] p);
      logic [31:0] sum;
      sum = {17'd0, p[45:31]} + {1'b0, p[30:0]};
      if (sum >= PM_M) begin
         sum = sum - PM_M;
      end
      return sum[30:0];
   endfunction

endpackage

// ===== rtl/core/rlr_dp.sv =====
// Datapath: generator state, shuffle table memory, multiply/reduce and
// a bit-serial remainder unit. Depends on rlr_pkg; driven by rlr_ctrl.
module rlr_dp import rlr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic [31:0] req_seed,
   input  logic [31:0] req_low,
   input  logic [31:0] req_high,
   output logic [31:0] rsp_value
);

   logic [31:0]       lcg_ff, lcg_in;
   logic [30:0]       last_ff, last_in;
   logic [30:0]       v_ff, v_in;
   logic [PROD_W-1:0] prod_ff;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [31:0]       low_ff, high_ff;
   logic [31:0]       dvd_ff, dvd_in, rem_ff, rem_in;
   logic [4:0]        dcnt_ff, dcnt_in;
   logic [31:0]       limit_ff;
   logic [31:0]       res_ff;
   logic [31:0]       out_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [30:0]       ram_q_ff;
   logic [30:0]       tbl [TABLE_DEPTH];

   logic [30:0]       red_v;
   logic [30:0]       start_v;
   logic [31:0]       width;
   logic [31:0]       rem_sh;
   logic [IDX_W-1:0]  rd_idx;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [30:0]       wr_data;

   assign red_v  = pm_fold(prod_ff);
   assign width  = high_ff - low_ff + 32'd1;
   assign rd_idx = last_ff[IDX_LSB +: IDX_W];
   assign rem_sh = {rem_ff[30:0], dvd_ff[31]};

   // negative seeds (except the most negative) start at their magnitude
   always_comb begin
      if (lcg_ff[31] && lcg_ff != HALF_WORD) begin
         start_v = 31'(32'd0 - lcg_ff);
      end else begin
         start_v = 31'd1;
      end
   end

   assign stat.warm_need  = lcg_ff[31] || (lcg_ff == 32'd0) || (last_ff == 31'd0);
   assign stat.warm_last  = (cnt_ff == '0);
   assign stat.degenerate = (width <= 32'd1) || ((width - 32'd1) > PM_M);
   assign stat.div_last   = (dcnt_ff == 5'd0);
   assign stat.reject     = ({1'b0, last_ff} > limit_ff);

   always_comb begin
      lcg_in  = lcg_ff;
      last_in = last_ff;
      v_in    = v_ff;
      cnt_in  = cnt_ff;
      if (cmd.seed_load) begin
         lcg_in  = req_seed[31] ? req_seed : 32'd0 - req_seed;
         last_in = '0;
      end
      if (cmd.draw_init) begin
         v_in   = stat.warm_need ? start_v : lcg_ff[30:0];
         cnt_in = CNT_W'(WARM_STEPS - 1);
      end
      if (cmd.warm_red) begin
         v_in   = red_v;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            last_in = red_v;
         end
      end
      if (cmd.step_red) begin
         v_in   = red_v;
         lcg_in = {1'b0, red_v};
      end
      if (cmd.swap) begin
         last_in = ram_q_ff;
      end
   end

   // remainder unit, one quotient bit per cycle
   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dcnt_in = dcnt_ff;
      if (cmd.div_lim_start || cmd.div_mod_start) begin
         dvd_in  = cmd.div_lim_start ? HALF_WORD : {1'b0, last_ff};
         rem_in  = '0;
         dcnt_in = 5'd31;
      end else if (cmd.div_step) begin
         dvd_in  = {dvd_ff[30:0], 1'b0};
         rem_in  = (rem_sh >= width) ? rem_sh - width : rem_sh;
         dcnt_in = dcnt_ff - 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lcg_ff  <= '0;
         last_ff <= '0;
      end else begin
         lcg_ff  <= lcg_in;
         last_ff <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff    <= v_in;
      cnt_ff  <= cnt_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      dcnt_ff <= dcnt_in;
      if (cmd.mul) begin
         prod_ff <= PROD_W'(v_ff) * PROD_W'(PM_A);
      end
      if (cmd.capture) begin
         low_ff  <= req_low;
         high_ff <= req_high;
      end
      if (cmd.lim_save) begin
         limit_ff <= PM_M - rem_ff;
      end
      if (cmd.step_red) begin
         idx_ff <= rd_idx;
      end
      if (cmd.res_low) begin
         res_ff <= low_ff;
      end else if (cmd.res_draw) begin
         res_ff <= {1'b0, ram_q_ff};
      end else if (cmd.res_mod) begin
         res_ff <= low_ff + rem_ff;
      end
      if (cmd.out_load) begin
         out_ff <= res_ff;
      end
   end

   // table: one write port, one registered read port
   assign wr_en   = cmd.swap || (cmd.warm_red && (cnt_ff < CNT_W'(TABLE_DEPTH)));
   assign wr_addr = cmd.swap ? idx_ff : cnt_ff[IDX_W-1:0];
   assign wr_data = cmd.swap ? lcg_ff[30:0] : red_v;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tbl[wr_addr] <= wr_data;
      end
      if (cmd.step_red) begin
         ram_q_ff <= tbl[rd_idx];
      end
   end

   assign rsp_value = out_ff;

endmodule

// ===== rtl/core/rlr_ctrl.sv =====
// Sequencer for the shuffled LCG range unit: handshakes and datapath commands.
// Depends on rlr_pkg; steers rlr_dp.
module rlr_ctrl import rlr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_kind,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  stat_type   stat,
   output cmd_type    cmd
);

   typedef enum logic [13:0] {
      ST_IDLE       = 14'b00000000000001,
      ST_DRAW_START = 14'b00000000000010,
      ST_WARM_MUL   = 14'b00000000000100,
      ST_WARM_RED   = 14'b00000000001000,
      ST_STEP_MUL   = 14'b00000000010000,
      ST_STEP_RED   = 14'b00000000100000,
      ST_SWAP       = 14'b00000001000000,
      ST_RANGE_CHK  = 14'b00000010000000,
      ST_DIV_LIM    = 14'b00000100000000,
      ST_LIM_SAVE   = 14'b00001000000000,
      ST_CHECK      = 14'b00010000000000,
      ST_DIV_MOD    = 14'b00100000000000,
      ST_RES_MOD    = 14'b01000000000000,
      ST_DONE       = 14'b10000000000000
   } state_type;

   state_type  state_ff, state_in;
   logic       ranged_ff, ranged_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in  = state_ff;
      ranged_in = ranged_ff;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               ranged_in   = (req_kind == KIND_RANGE);
               if (req_kind == KIND_SEED) begin
                  cmd.seed_load = 1'b1;
               end else if (req_kind == KIND_DRAW) begin
                  state_in = ST_DRAW_START;
               end else if (req_kind == KIND_RANGE) begin
                  state_in = ST_RANGE_CHK;
               end
            end
         end
         ST_DRAW_START: begin
            cmd.draw_init = 1'b1;
            state_in = stat.warm_need ? ST_WARM_MUL : ST_STEP_MUL;
         end
         ST_WARM_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_WARM_RED;
         end
         ST_WARM_RED: begin
            cmd.warm_red = 1'b1;
            state_in = stat.warm_last ? ST_STEP_MUL : ST_WARM_MUL;
         end
         ST_STEP_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_STEP_RED;
         end
         ST_STEP_RED: begin
            cmd.step_red = 1'b1;
            state_in = ST_SWAP;
         end
         ST_SWAP: begin
            cmd.swap = 1'b1;
            if (ranged_ff) begin
               state_in = ST_CHECK;
            end else begin
               cmd.res_draw = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_RANGE_CHK: begin
            if (stat.degenerate) begin
               cmd.res_low = 1'b1;
               state_in = ST_DONE;
            end else begin
               cmd.div_lim_start = 1'b1;
               state_in = ST_DIV_LIM;
            end
         end
         ST_DIV_LIM: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = ST_LIM_SAVE;
            end
         end
         ST_LIM_SAVE: begin
            cmd.lim_save = 1'b1;
            state_in = ST_DRAW_START;
         end
         ST_CHECK: begin
            if (stat.reject) begin
               state_in = ST_DRAW_START;
            end else begin
               cmd.div_mod_start = 1'b1;
               state_in = ST_DIV_MOD;
            end
         end
         ST_DIV_MOD: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = ST_RES_MOD;
            end
         end
         ST_RES_MOD: begin
            cmd.res_mod = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ranged_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ranged_ff    <= ranged_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/shuffled_lcg_random_range_unit.sv =====
// Top level of the shuffled LCG random range unit.
// Depends on rlr_pkg, rlr_ctrl and rlr_dp.
//
// Usage:
//  - req_ channel takes one word per item: kind, seed, low, high.
//    kind 0 loads a seed (no response), kind 1 returns a raw draw,
//    kind 2 returns a uniform integer in [low, high]; kind 3 is dropped.
//  - rsp_ channel returns one word (rsp_value) for each kind 1 or 2 item.
//  - One item is in flight at a time; req_ready is high only while idle.
//    A seed load completes without leaving idle.
//  - A raw draw runs one generator step and a table swap; the first draw
//    after reset or a seed load adds the table warm-up, 40 generator steps.
//    The generator step is a 15x31 multiply, then a mod (2^31-1) fold.
//  - A ranged draw adds a remainder pass for the rejection limit and one for
//    the final remainder (bit-serial remainder unit, one bit per cycle),
//    plus a redraw for every rejected draw. A single-value, empty or
//    over-wide range returns low with no draw.
//  - The response sits in an output register; the next item is accepted
//    while it waits. If the receiver stalls, the following result holds in
//    the datapath result register until the output register frees up.
//  - Reset (synchronous) clears the generator state and output valid; the
//    table is always refilled by warm-up before it is read.
module shuffled_lcg_random_range_unit import rlr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_seed,
   input  logic [31:0] req_low,
   input  logic [31:0] req_high,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_value
);

   cmd_type  cmd;
   stat_type stat;

   rlr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rlr_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_seed  (req_seed),
      .req_low   (req_low),
      .req_high  (req_high),
      .rsp_value (rsp_value)
   );

   // reset leaves the unit idle with nothing to deliver
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (req_ready && !rsp_valid))
      else $error("unit not idle after reset");

   // a seed load leaves the unit ready again in the next cycle
   a_seed_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_kind == KIND_SEED) |=> req_ready)
      else $error("seed load did not return to idle");

   // no response word can appear the cycle after a draw is taken
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_kind == KIND_DRAW || req_kind == KIND_RANGE))
      |=> !$rose(rsp_valid))
      else $error("response raised too early");

endmodule
